[design/lwma_pkg.sv]
// Shared types, constants and compact-target decoding for the LWMA retarget block.
package lwma_pkg;

  localparam int TIME_W    = 32;
  localparam int CODE_W    = 32;
  localparam int VAL_W     = 256;
  localparam int SPACING_W = 16;
  localparam int WSIZE_W   = 8;
  localparam int LIMW_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int SOLVE_W   = 19;
  localparam int CAP_MUL   = 6;
  localparam int DIV_STEPS = 256;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPACING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POW_LIMIT0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POW_LIMIT1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POW_LIMIT2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POW_LIMIT3     = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0] block_time;
    logic [CODE_W-1:0] compact_target;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] next_compact_target;
    logic              limit_used;
  } out_item_t;

  // Sign bit and overflow ignored; bits shifted past 255 are dropped.
  function automatic logic [VAL_W-1:0] decode_compact(input logic [CODE_W-1:0] c);
    logic [7:0]       size;
    logic [7:0]       sh;
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] r;
    size = c[31:24];
    m    = {{(VAL_W-23){1'b0}}, c[22:0]};
    if (size <= 8'd3) begin
      sh = 8'd3 - size;
      r  = m >> {sh[1:0], 3'b000};
    end else if (size <= 8'd34) begin
      sh = size - 8'd3;
      r  = m << {sh[4:0], 3'b000};
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

[design/lwma_ifs.sv]
// Valid/ready channel interfaces for block items and retarget results.
interface lwma_in_if;
  logic                valid;
  logic                ready;
  lwma_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lwma_out_if;
  logic                valid;
  logic                ready;
  lwma_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/lwma_ring.sv]
// Timestamp and scaled-target ring memories, one write and one registered read port.
module lwma_ring #(
  parameter int DEPTH = 129,
  parameter int AW    = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [lwma_pkg::TIME_W-1:0]  wtime,
  input  logic [lwma_pkg::VAL_W-1:0]   wtarget,
  input  logic [AW-1:0]                raddr,
  output logic [lwma_pkg::TIME_W-1:0]  rtime,
  output logic [lwma_pkg::VAL_W-1:0]   rtarget
);

  logic [lwma_pkg::TIME_W-1:0] time_mem [DEPTH];
  logic [lwma_pkg::VAL_W-1:0]  tgt_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= wtime;
      tgt_mem[waddr]  <= wtarget;
    end
    rtime   <= time_mem[raddr];
    rtarget <= tgt_mem[raddr];
  end

endmodule

[design/lwma_div.sv]
// Bit-serial restoring divider: 256-bit dividend by a narrow divisor, one bit a cycle.
module lwma_div #(
  parameter int DW = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lwma_pkg::VAL_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       done,
  output logic [lwma_pkg::VAL_W-1:0] quotient
);

  logic          busy;
  logic [7:0]    cnt;
  logic [DW-1:0] rem;
  logic [DW:0]   sh;
  logic          qbit;

  always_comb begin
    sh   = {rem, quotient[lwma_pkg::VAL_W-1]};
    qbit = (sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        cnt      <= 8'(lwma_pkg::DIV_STEPS - 1);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= qbit ? DW'(sh - {1'b0, divisor}) : sh[DW-1:0];
        quotient <= {quotient[lwma_pkg::VAL_W-2:0], qbit};
        if (cnt == 8'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 8'd1;
        end
      end
    end
  end

endmodule

[design/lwma_enc.sv]
// Compact nBits encoder: scans down one byte a cycle to the top nonzero byte.
module lwma_enc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lwma_pkg::VAL_W-1:0]  value,
  output logic                        done,
  output logic [lwma_pkg::CODE_W-1:0] code
);

  logic                       busy;
  logic [lwma_pkg::VAL_W-1:0] v;
  logic [5:0]                 sz;
  logic [23:0]                mant;
  logic [7:0]                 size;

  assign done = busy && (sz == 6'd0 || v[255:248] != 8'd0);

  always_comb begin
    mant = v[255:232];
    size = {2'b00, sz};
    if (mant[23]) begin
      mant = {8'd0, mant[23:8]};
      size = size + 8'd1;
    end
    code = {size, mant};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      v    <= value;
      sz   <= 6'd32;
      busy <= 1'b1;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        v  <= {v[247:0], 8'd0};
        sz <= sz - 6'd1;
      end
    end
  end

endmodule

[design/lwma1_difficulty_retarget.sv]
// LWMA-1 retarget: one block (timestamp, compact target) in, one compact target for the
// next block out. With the window filled (N = window size), an accepted item passes through
// the setup states S_MUL1, S_MUL2, S_MUL3 and S_DSTART, a serial divide scaling the new
// target, a store state, a walk reading the N + 1 ring entries of the window, a serial
// multiply over the SOLVE_W + 2*clog2(MAX_WINDOW+1) bits of the weighted sum (35 at the
// default), a compare state, the encoder scan and the output state. During warm-up the
// walk, multiply and compare are skipped and the limit is encoded. A new block is taken the
// cycle after the result is loaded, while that result waits in the output register; the
// output state stalls only while the previous result transaction is still pending.
module lwma1_difficulty_retarget #(
  parameter int MAX_WINDOW = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lwma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lwma_pkg::LIMW_W-1:0]    cfg_data,
  lwma_in_if.sink                        block_chan,
  lwma_out_if.source                     result_chan
);

  localparam int RING_LEN = MAX_WINDOW + 1;
  localparam int AW       = $clog2(RING_LEN);
  localparam int NW       = $clog2(MAX_WINDOW + 1);
  localparam int HW       = $clog2(RING_LEN + 1);
  localparam int P1W      = 2 * NW + 1;
  localparam int KW       = P1W + lwma_pkg::SPACING_W;
  localparam int DW       = KW + NW;
  localparam int SW       = lwma_pkg::SOLVE_W;
  localparam int WW       = SW + 2 * NW;
  localparam int PW       = lwma_pkg::TIME_W + NW + 1;
  localparam int MCW      = $clog2(WW);
  localparam int VW       = lwma_pkg::VAL_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_MUL2   = 4'd2;
  localparam logic [3:0] S_MUL3   = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_STORE  = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_PROD   = 4'd8;
  localparam logic [3:0] S_CMP    = 4'd9;
  localparam logic [3:0] S_ENC    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [lwma_pkg::SPACING_W-1:0] target_spacing;
  logic [lwma_pkg::WSIZE_W-1:0]   window_size;
  logic [lwma_pkg::LIMW_W-1:0]    pow_limit0, pow_limit1, pow_limit2, pow_limit3;
  logic [VW-1:0]                  limit;

  logic [3:0]                     state;
  logic [HW-1:0]                  held;
  logic [AW-1:0]                  head;
  logic [lwma_pkg::TIME_W-1:0]    in_time;
  logic [lwma_pkg::CODE_W-1:0]    in_code;
  logic [NW-1:0]                  n_r;
  logic [lwma_pkg::SPACING_W-1:0] t_r;
  logic [SW-1:0]                  six_t;
  logic [P1W-1:0]                 p1;
  logic [KW-1:0]                  k;
  logic [DW-1:0]                  d;

  logic [AW-1:0]                  rd_addr;
  logic [NW-1:0]                  rd_cnt;
  logic                           issuing;
  logic                           rvalid;
  logic [NW-1:0]                  rj;
  logic [PW-1:0]                  prev;
  logic [WW-1:0]                  weighted;
  logic [VW-1:0]                  sum;
  logic [VW-1:0]                  acc;
  logic [MCW-1:0]                 mcnt;
  logic                           res_flag;
  logic [lwma_pkg::CODE_W-1:0]    res_code;
  logic                           out_valid;
  lwma_pkg::out_item_t            out_data;

  logic [NW-1:0]                  n_eff;
  logic [lwma_pkg::SPACING_W-1:0] t_eff;
  logic [AW-1:0]                  head_inc;
  logic [HW-1:0]                  held_inc;
  logic [AW:0]                    st;
  logic [AW-1:0]                  rd_inc;
  logic [PW-1:0]                  tz, ts, diff;
  logic [SW-1:0]                  capped;
  logic [WW-1:0]                  term;
  logic                           warm;
  logic                           gt;

  logic                           div_start, div_done;
  logic [VW-1:0]                  quotient;
  logic                           enc_start, enc_done;
  logic [VW-1:0]                  enc_value;
  logic [lwma_pkg::CODE_W-1:0]    enc_code;
  logic [lwma_pkg::TIME_W-1:0]    rd_time;
  logic [VW-1:0]                  rd_target;
  logic                           in_accept;
  logic                           load_out;

  assign limit     = {pow_limit3, pow_limit2, pow_limit1, pow_limit0};
  assign block_chan.ready  = (state == S_IDLE);
  assign in_accept = block_chan.valid && block_chan.ready;
  assign result_chan.valid = out_valid;
  assign result_chan.data  = out_data;
  assign load_out  = (state == S_OUT) && (!out_valid || result_chan.ready);

  always_comb begin
    if (window_size < 8'd2) begin
      n_eff = NW'(2);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(window_size);
    end
    t_eff = (target_spacing == '0) ? lwma_pkg::SPACING_W'(1) : target_spacing;

    head_inc = (head == AW'(RING_LEN - 1)) ? '0 : head + AW'(1);
    held_inc = (held == HW'(RING_LEN)) ? held : held + HW'(1);
    warm     = (held_inc <= HW'(n_r));
    if ({1'b0, head} >= (AW+1)'(n_r)) begin
      st = {1'b0, head} - (AW+1)'(n_r);
    end else begin
      st = {1'b0, head} + (AW+1)'(RING_LEN) - (AW+1)'(n_r);
    end
    rd_inc = (rd_addr == AW'(RING_LEN - 1)) ? '0 : rd_addr + AW'(1);

    tz     = PW'(rd_time);
    ts     = (tz > prev) ? tz : prev + PW'(1);
    diff   = ts - prev;
    capped = (diff > PW'(six_t)) ? six_t : SW'(diff);
    term   = WW'(capped) * WW'(rj);

    gt        = (acc > limit);
    div_start = (state == S_DSTART);
    enc_start = (state == S_STORE && warm) || (state == S_CMP);
    enc_value = (state == S_CMP && !gt) ? acc : limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_spacing <= 16'd60;
      window_size    <= 8'd60;
      pow_limit0     <= '1;
      pow_limit1     <= '1;
      pow_limit2     <= '1;
      pow_limit3     <= 64'h0FFF_FFFF_FFFF_FFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        lwma_pkg::REG_TARGET_SPACING: target_spacing <= cfg_data[lwma_pkg::SPACING_W-1:0];
        lwma_pkg::REG_WINDOW_SIZE:    window_size    <= cfg_data[lwma_pkg::WSIZE_W-1:0];
        lwma_pkg::REG_POW_LIMIT0:     pow_limit0     <= cfg_data;
        lwma_pkg::REG_POW_LIMIT1:     pow_limit1     <= cfg_data;
        lwma_pkg::REG_POW_LIMIT2:     pow_limit2     <= cfg_data;
        lwma_pkg::REG_POW_LIMIT3:     pow_limit3     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid                    <= 1'b1;
      out_data.next_compact_target <= res_code;
      out_data.limit_used          <= res_flag;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      head      <= '0;
      issuing   <= 1'b0;
      rvalid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            in_time <= block_chan.data.block_time;
            in_code <= block_chan.data.compact_target;
            n_r     <= n_eff;
            t_r     <= t_eff;
            if (block_chan.data.restart) begin
              head <= '0;
              held <= '0;
            end
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1    <= P1W'(n_r) * P1W'({1'b0, n_r} + (NW+1)'(1));
          six_t <= SW'(t_r) * SW'(lwma_pkg::CAP_MUL);
          state <= S_MUL2;
        end
        S_MUL2: begin
          k     <= (KW'(p1) * KW'(t_r)) >> 1;
          state <= S_MUL3;
        end
        S_MUL3: begin
          d     <= DW'(k) * DW'(n_r);
          state <= S_DSTART;
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          head <= head_inc;
          held <= held_inc;
          if (warm) begin
            res_flag <= 1'b1;
            state    <= S_ENC;
          end else begin
            rd_addr  <= st[AW-1:0];
            rd_cnt   <= '0;
            issuing  <= 1'b1;
            rvalid   <= 1'b0;
            weighted <= '0;
            sum      <= '0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          rvalid <= issuing;
          rj     <= rd_cnt;
          if (issuing) begin
            rd_addr <= rd_inc;
            if (rd_cnt == n_r) begin
              issuing <= 1'b0;
            end else begin
              rd_cnt <= rd_cnt + NW'(1);
            end
          end
          if (rvalid) begin
            if (rj == '0) begin
              prev <= tz;
            end else begin
              prev     <= ts;
              weighted <= weighted + term;
              sum      <= sum + rd_target;
            end
            if (rj == n_r) begin
              acc   <= '0;
              mcnt  <= MCW'(WW - 1);
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          acc <= (acc << 1) + (weighted[mcnt] ? sum : '0);
          if (mcnt == '0) begin
            state <= S_CMP;
          end else begin
            mcnt <= mcnt - MCW'(1);
          end
        end
        S_CMP: begin
          res_flag <= gt;
          state    <= S_ENC;
        end
        S_ENC: begin
          if (enc_done) begin
            res_code <= enc_code;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lwma_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lwma_pkg::decode_compact(in_code)),
    .divisor  (d),
    .done     (div_done),
    .quotient (quotient)
  );

  lwma_ring #(.DEPTH(RING_LEN), .AW(AW)) u_ring (
    .clk     (clk),
    .we      (state == S_STORE),
    .waddr   (head),
    .wtime   (in_time),
    .wtarget (quotient),
    .raddr   (rd_addr),
    .rtime   (rd_time),
    .rtarget (rd_target)
  );

  lwma_enc u_enc (
    .clk   (clk),
    .rst   (rst),
    .start (enc_start),
    .value (enc_value),
    .done  (enc_done),
    .code  (enc_code)
  );

endmodule
